### sv/gpgs_pkg.sv
package gpgs_pkg;

    // field widths of the item channels
    localparam int CMD_W    = 2;
    localparam int POINT_W  = 10;
    localparam int LINE_W   = 12;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 11;
    localparam int HIT_W    = 2;

    // default sizes
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_MAX_LINES  = 4096;
    localparam int DEF_MAX_DEGREE = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VISIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TAKEN    = 2'd2;

    // line hit counter: a line is full at two picked points, counter saturates at three
    localparam logic [HIT_W-1:0]   HIT_LIMIT = 2'd2;
    localparam logic [HIT_W-1:0]   HIT_SAT   = 2'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 11'd2047;

    typedef logic [HIT_W-1:0] hit_t;

    function automatic hit_t hit_inc(input hit_t h);
        return (h == HIT_SAT) ? h : h + hit_t'(1);
    endfunction

endpackage

### sv/gpgs_req_if.sv
interface gpgs_req_if;
    import gpgs_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [POINT_W-1:0] point;
    logic [LINE_W-1:0]  line;

    modport source (output valid, cmd, point, line, input ready);
    modport sink   (input valid, cmd, point, line, output ready);
endinterface

### sv/gpgs_rsp_if.sv
interface gpgs_rsp_if;
    import gpgs_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                accepted;
    logic [TOTAL_W-1:0]  accepted_total;

    modport source (output valid, status, accepted, accepted_total, input ready);
    modport sink   (input valid, status, accepted, accepted_total, output ready);
endinterface

### sv/general_position_greedy_select.sv
// Greedy selection of points in general position.
// req channel (valid/ready): cmd, point, line. cmd add records that point lies on
// line; cmd visit tries to pick point; cmd clear drops all picks and line counters
// but keeps the incidences. rsp channel (valid/ready): exactly one item per
// request item, carrying status, accepted and the running accepted_total.
// One item is in flight at a time. An item is taken only when the block is idle;
// the result sits in an output register, so the next item is taken while that
// result still waits for rsp.ready. A stalled receiver holds the block only once
// the next result is finished.
// An add passes through a counter update state if the point is already picked.
// A visit walks the point's lines through the line list and line counter
// memories, each giving one read per cycle, twice (check pass, then update
// pass); a rejected visit ends after the check pass.
// Clear sweeps the counter and pick memories over max(MAX_POINTS, MAX_LINES)
// addresses (4096 by default), then answers.
// After reset the same sweep also zeroes the degree memory before the first
// item is taken, with req.ready low.
module general_position_greedy_select
#(
    parameter int MAX_POINTS = gpgs_pkg::DEF_MAX_POINTS,
    parameter int MAX_LINES  = gpgs_pkg::DEF_MAX_LINES,
    parameter int MAX_DEGREE = gpgs_pkg::DEF_MAX_DEGREE
) (
    input  logic             clk,
    input  logic             rst_n,
    gpgs_req_if.sink         req,
    gpgs_rsp_if.source       rsp
);
    import gpgs_pkg::*;

    localparam int PW      = $clog2(MAX_POINTS);
    localparam int LW      = $clog2(MAX_LINES);
    localparam int DW      = $clog2(MAX_DEGREE + 1);
    localparam int JW      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int AW      = PW + JW;
    localparam int SWEEP_N = (MAX_POINTS > MAX_LINES) ? MAX_POINTS : MAX_LINES;
    localparam int SW      = $clog2(SWEEP_N);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_ADDB  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    // memories
    logic [DW-1:0] deg_mem    [MAX_POINTS];
    logic          chosen_mem [MAX_POINTS];
    logic [LW-1:0] list_mem   [MAX_POINTS << JW];
    hit_t          hit_mem    [MAX_LINES];

    logic          deg_we, chosen_we, list_we, hit_we;
    logic [PW-1:0] deg_waddr, chosen_waddr, deg_raddr;
    logic [DW-1:0] deg_wdata, deg_rd;
    logic          chosen_wdata, chosen_rd;
    logic [AW-1:0] list_waddr, list_raddr;
    logic [LW-1:0] list_wdata, list_rd;
    logic [LW-1:0] hit_waddr, hit_raddr;
    hit_t          hit_wdata, hit_rd;

    // control and item registers
    logic [2:0]          state_reg, state_next;
    logic                init_reg, init_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [POINT_W-1:0]  pt_reg, pt_next;
    logic [LINE_W-1:0]   ln_in_reg, ln_in_next;
    logic [DW-1:0]       deg_reg, deg_next;
    logic                bump_reg, bump_next;
    logic                fail_reg, fail_next;
    logic [DW-1:0]       iss_cnt_reg, iss_cnt_next;
    logic                v1_reg, v1_next;
    logic                v2_reg, v2_next;
    logic [LW-1:0]       lnp_reg, lnp_next;
    logic                fwd_v_reg, fwd_v_next;
    logic [LW-1:0]       fwd_addr_reg, fwd_addr_next;
    hit_t                fwd_data_reg, fwd_data_next;
    logic [SW-1:0]       sw_cnt_reg, sw_cnt_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_acc_reg, res_acc_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_acc_reg, out_acc_next;
    logic [TOTAL_W-1:0]  out_total_reg, out_total_next;

    logic          pt_ok, ln_ok, issue, load;
    logic [PW-1:0] pt_a;
    hit_t          hval;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.accepted       = out_acc_reg;
    assign rsp.accepted_total = out_total_reg;

    assign pt_a      = PW'(pt_reg);
    assign pt_ok     = int'(pt_reg) < MAX_POINTS;
    assign ln_ok     = int'(ln_in_reg) < MAX_LINES;
    assign deg_raddr = PW'(req.point);
    assign list_raddr = {pt_a, iss_cnt_reg[JW-1:0]};
    assign hit_raddr = (state_reg == S_SCAN) ? list_rd : LW'(ln_in_reg);
    assign issue     = iss_cnt_reg < deg_reg;
    // a counter read issued in the cycle of the previous write to the same line
    // returns stale data: take the written value instead
    assign hval      = (fwd_v_reg && fwd_addr_reg == lnp_reg) ? fwd_data_reg : hit_rd;
    assign load      = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_rd <= deg_mem[deg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (chosen_we)
        begin
            chosen_mem[chosen_waddr] <= chosen_wdata;
        end
        chosen_rd <= chosen_mem[deg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
        list_rd <= list_mem[list_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hit_we)
        begin
            hit_mem[hit_waddr] <= hit_wdata;
        end
        hit_rd <= hit_mem[hit_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        cmd_next        = cmd_reg;
        pt_next         = pt_reg;
        ln_in_next      = ln_in_reg;
        deg_next        = deg_reg;
        bump_next       = bump_reg;
        fail_next       = fail_reg;
        iss_cnt_next    = iss_cnt_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        lnp_next        = lnp_reg;
        fwd_v_next      = 1'b0;
        fwd_addr_next   = fwd_addr_reg;
        fwd_data_next   = fwd_data_reg;
        sw_cnt_next     = sw_cnt_reg;
        total_next      = total_reg;
        res_status_next = res_status_reg;
        res_acc_next    = res_acc_reg;

        deg_we       = 1'b0;
        deg_waddr    = pt_a;
        deg_wdata    = deg_rd + DW'(1);
        chosen_we    = 1'b0;
        chosen_waddr = pt_a;
        chosen_wdata = 1'b1;
        list_we      = 1'b0;
        list_waddr   = {pt_a, deg_rd[JW-1:0]};
        list_wdata   = LW'(ln_in_reg);
        hit_we       = 1'b0;
        hit_waddr    = lnp_reg;
        hit_wdata    = hit_inc(hval);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    pt_next    = req.point;
                    ln_in_next = req.line;
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                res_status_next = ST_OK;
                res_acc_next    = 1'b0;
                deg_next        = deg_rd;
                bump_next       = 1'b0;
                fail_next       = 1'b0;
                iss_cnt_next    = '0;
                v1_next         = 1'b0;
                v2_next         = 1'b0;
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (!pt_ok || !ln_ok || int'(deg_rd) >= MAX_DEGREE)
                        begin
                            res_status_next = ST_OVERFLOW;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            list_we    = 1'b1;
                            deg_we     = 1'b1;
                            // a picked point keeps its new line's counter current
                            state_next = chosen_rd ? S_ADDB : S_RESP;
                        end
                    end
                    CMD_VISIT:
                    begin
                        if (!pt_ok)
                        begin
                            res_status_next = ST_OVERFLOW;
                            state_next      = S_RESP;
                        end
                        else if (chosen_rd)
                        begin
                            res_status_next = ST_TAKEN;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        sw_cnt_next = '0;
                        state_next  = S_SWEEP;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_ADDB:
            begin
                hit_we     = 1'b1;
                hit_waddr  = LW'(ln_in_reg);
                hit_wdata  = hit_inc(hit_rd);
                state_next = S_RESP;
            end

            S_SCAN:
            begin
                // list read -> counter read -> check or update, one line per cycle
                if (issue)
                begin
                    iss_cnt_next = iss_cnt_reg + DW'(1);
                end
                v1_next  = issue;
                v2_next  = v1_reg;
                lnp_next = list_rd;
                if (v2_reg)
                begin
                    if (bump_reg)
                    begin
                        hit_we        = 1'b1;
                        fwd_v_next    = 1'b1;
                        fwd_addr_next = lnp_reg;
                        fwd_data_next = hit_inc(hval);
                    end
                    else if (hval >= HIT_LIMIT)
                    begin
                        fail_next = 1'b1;
                    end
                end
                if (!issue && !v1_reg && !v2_reg)
                begin
                    if (!bump_reg)
                    begin
                        if (fail_reg)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            bump_next    = 1'b1;
                            iss_cnt_next = '0;
                        end
                    end
                    else
                    begin
                        chosen_we    = 1'b1;
                        res_acc_next = 1'b1;
                        if (total_reg < TOTAL_MAX)
                        begin
                            total_next = total_reg + TOTAL_W'(1);
                        end
                        state_next = S_RESP;
                    end
                end
            end

            S_SWEEP:
            begin
                deg_waddr    = PW'(sw_cnt_reg);
                deg_wdata    = '0;
                chosen_waddr = PW'(sw_cnt_reg);
                chosen_wdata = 1'b0;
                hit_waddr    = LW'(sw_cnt_reg);
                hit_wdata    = '0;
                if (int'(sw_cnt_reg) < MAX_POINTS)
                begin
                    chosen_we = 1'b1;
                    deg_we    = init_reg;
                end
                if (int'(sw_cnt_reg) < MAX_LINES)
                begin
                    hit_we = 1'b1;
                end
                if (sw_cnt_reg == SW'(SWEEP_N - 1))
                begin
                    total_next = '0;
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    sw_cnt_next = sw_cnt_reg + SW'(1);
                end
            end

            S_RESP:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_acc_next    = out_acc_reg;
        out_total_next  = out_total_reg;
        if (load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_acc_next    = res_acc_reg;
            out_total_next  = total_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            init_reg      <= 1'b1;
            sw_cnt_reg    <= '0;
            total_reg     <= '0;
            bump_reg      <= 1'b0;
            fail_reg      <= 1'b0;
            iss_cnt_reg   <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            fwd_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            sw_cnt_reg    <= sw_cnt_next;
            total_reg     <= total_next;
            bump_reg      <= bump_next;
            fail_reg      <= fail_next;
            iss_cnt_reg   <= iss_cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            fwd_v_reg     <= fwd_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pt_reg         <= pt_next;
        ln_in_reg      <= ln_in_next;
        deg_reg        <= deg_next;
        lnp_reg        <= lnp_next;
        fwd_addr_reg   <= fwd_addr_next;
        fwd_data_reg   <= fwd_data_next;
        res_status_reg <= res_status_next;
        res_acc_reg    <= res_acc_next;
        out_status_reg <= out_status_next;
        out_acc_reg    <= out_acc_next;
        out_total_reg  <= out_total_next;
    end

    // checks

    a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.accepted |-> rsp.status == ST_OK)
        else $error("accepted result with non-ok status");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> iss_cnt_reg <= deg_reg)
        else $error("line scan ran past point degree");

    a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && hit_we |-> bump_reg)
        else $error("line counter written during check pass");

    a_list_room: assert property (@(posedge clk) disable iff (!rst_n)
        list_we |-> int'(deg_rd) < MAX_DEGREE)
        else $error("line list written beyond degree limit");

    a_acc_total: assert property (@(posedge clk) disable iff (!rst_n)
        load && res_acc_reg |-> total_reg != '0)
        else $error("accepted visit left total at zero");

endmodule
